[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[hw/rtl/mtpc_pkg.sv]
package mtpc_pkg;

	// Command codes carried on s_tuser
	localparam logic [1:0] CMD_RESTART = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_CHECK   = 2'd2;

	// Pattern modes
	localparam logic [1:0] MODE_CONST = 2'd0;
	localparam logic [1:0] MODE_ADDR  = 2'd1;
	localparam logic [1:0] MODE_LCG   = 2'd2;

	// Configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_TEST_MODE     = 2'd0;
	localparam reg_idx_t REG_FILL_VALUE    = 2'd1;
	localparam reg_idx_t REG_START_ADDRESS = 2'd2;
	localparam reg_idx_t REG_LENGTH_BYTES  = 2'd3;

	localparam int unsigned   SEQ_W    = 31;
	localparam logic [30:0]   LCG_MUL  = 31'd1103515245;
	localparam logic [30:0]   LCG_ADD  = 31'd12345;
	localparam logic [31:0]   ALL_ONES = 32'hffff_ffff;
	localparam logic [31:0]   WORD_BYTES = 32'd4;

	typedef struct packed {
		logic [1:0]  test_mode;
		logic [31:0] fill_value;
		logic [31:0] start_address;
		logic [31:0] length_bytes;
	} cfg_t;

	typedef struct packed {
		logic [31:0] word_address;
		logic [31:0] pattern;
		logic        mismatch;
		logic        pass_done;
		logic [31:0] fail_address;
	} result_t;

	// One step of the sequence, modulo 2^31
	function automatic logic [SEQ_W-1:0] lcg_next(input logic [SEQ_W-1:0] s);
		logic [SEQ_W-1:0] prod;
		prod = s * LCG_MUL;
		return prod + LCG_ADD;
	endfunction

endpackage

[hw/rtl/mtpc_engine.sv]
module mtpc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [1:0]        cmd,
	input  logic [31:0]       read_data,
	input  mtpc_pkg::cfg_t    cfg,
	output mtpc_pkg::result_t result
);
	import mtpc_pkg::*;

	logic [31:0]      next_address_q;
	logic [31:0]      bytes_left_q;
	logic [31:0]      first_fail_q;
	logic             finished_q;
	// Sequence value the next word will use, computed one step ahead
	logic [SEQ_W-1:0] seq_next_q;

	logic [31:0] pat;
	logic        mis;
	logic        last_word;

	// Pick the pattern for the current address
	always_comb begin
		case (cfg.test_mode)
			MODE_ADDR: pat = next_address_q;
			MODE_LCG:  pat = {1'b0, seq_next_q};
			default:   pat = cfg.fill_value;
		endcase
		mis       = (cmd == CMD_CHECK) && (read_data != pat);
		last_word = (bytes_left_q <= WORD_BYTES);
	end

	// Build the result word for this command
	always_comb begin
		result.word_address = next_address_q;
		result.pattern      = '0;
		result.mismatch     = 1'b0;
		result.pass_done    = finished_q;
		result.fail_address = first_fail_q;
		case (cmd)
			CMD_RESTART: begin
				result.word_address = cfg.start_address;
				result.pass_done    = (cfg.length_bytes == '0);
				result.fail_address = ALL_ONES;
			end
			CMD_WRITE, CMD_CHECK: begin
				if (!finished_q) begin
					result.pattern   = pat;
					result.mismatch  = mis;
					result.pass_done = last_word | mis;
					if (mis)
						result.fail_address = next_address_q;
				end
			end
			default: ;
		endcase
	end

	// Advance the walk on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_address_q <= '0;
			bytes_left_q   <= '0;
			first_fail_q   <= ALL_ONES;
			finished_q     <= 1'b1;
			seq_next_q     <= LCG_ADD;
		end else if (step) begin
			case (cmd)
				CMD_RESTART: begin
					next_address_q <= cfg.start_address;
					bytes_left_q   <= cfg.length_bytes;
					first_fail_q   <= ALL_ONES;
					finished_q     <= (cfg.length_bytes == '0);
					seq_next_q     <= LCG_ADD;
				end
				CMD_WRITE, CMD_CHECK: begin
					if (!finished_q) begin
						next_address_q <= next_address_q + WORD_BYTES;
						bytes_left_q   <= last_word ? '0 : bytes_left_q - WORD_BYTES;
						finished_q     <= last_word | mis;
						if (mis)
							first_fail_q <= next_address_q;
						if (cfg.test_mode == MODE_LCG)
							seq_next_q <= lcg_next(seq_next_q);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/memory_test_pattern_checker.sv]
// Memory test pattern engine. Each input word carries a command on s_tuser
// (restart, produce next write word, check next read word) and the read-back
// word on s_tdata; each gives exactly one result word in the next cycle, with the
// handled address, the pattern, the first failing address (all ones if none),
// a mismatch flag on m_tuser and end of pass on m_tlast. The block takes one
// word per cycle; the walk state updates on each accepted word, and the
// next sequence value is kept one step ahead so the 31-bit multiplier sits in
// its own register path. A single output register holds the result; s_tready
// drops only while that register is full and m_tready is low. Configuration
// registers are written through cfg_we/cfg_index/cfg_data; mode and fill value
// apply to every word, start address and length only at restart.
module memory_test_pattern_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  mtpc_pkg::reg_idx_t  cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,   // [31:0] read_data
	input  logic [1:0]          s_tuser,   // [1:0] cmd
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [95:0]         m_tdata,   // [31:0] word_address, [63:32] pattern,
	                                       // [95:64] fail_address
	output logic                m_tuser,   // [0] mismatch
	output logic                m_tlast    // pass_done
);
	import mtpc_pkg::*;

	cfg_t    cfg_q;
	result_t result;
	result_t res_s1;
	logic    valid_s1;
	logic    accept;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEST_MODE:     cfg_q.test_mode     <= cfg_data[1:0];
				REG_FILL_VALUE:    cfg_q.fill_value    <= cfg_data;
				REG_START_ADDRESS: cfg_q.start_address <= cfg_data;
				REG_LENGTH_BYTES:  cfg_q.length_bytes  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	mtpc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.cmd       (s_tuser),
		.read_data (s_tdata),
		.cfg       (cfg_q),
		.result    (result)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (m_tready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (accept)
			res_s1 <= result;
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {res_s1.fail_address, res_s1.pattern, res_s1.word_address};
	assign m_tuser  = res_s1.mismatch;
	assign m_tlast  = res_s1.pass_done;

endmodule

[hw/rtl/mtpc_checker.sv]
`include "assert_macros.svh"

module mtpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import mtpc_pkg::*;

	logic [31:0] word_addr;
	logic [31:0] fail_addr;
	logic        restart_word;

	assign word_addr    = m_tdata[31:0];
	assign fail_addr    = m_tdata[95:64];
	assign restart_word = s_tvalid && s_tready && (s_tuser == CMD_RESTART);

	// Stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A mismatch always ends the pass
	`ASSERT_IMPLIES(a_mis_done, clk, arst_n, m_tvalid && m_tuser, m_tlast)

	// A mismatch reports its own address as the failing one
	`ASSERT_IMPLIES(a_mis_addr, clk, arst_n, m_tvalid && m_tuser, fail_addr == word_addr)

	// Restart clears the failing address in the next result
	`ASSERT_NEXT(a_restart, clk, arst_n, restart_word, m_tvalid && fail_addr == ALL_ONES && !m_tuser)

endmodule

bind memory_test_pattern_checker mtpc_checker u_mtpc_checker (.*);

[sim/testbench.sv]
module testbench;
	import mtpc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Sequence step, modulo 2^31
	localparam logic [30:0] SEQ_STEP_MUL = 31'd1103515245;
	localparam logic [30:0] SEQ_STEP_INC = 31'd12345;

	localparam int unsigned RANDOM_ITEMS = 1024;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] read_data
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // [31:0] word_address, [63:32] pattern, [95:64] fail_address
	logic        m_tuser;   // [0] mismatch
	logic        m_tlast;   // pass_done

	// Register copies
	logic [1:0]  cur_mode;
	logic [31:0] cur_fill;
	logic [31:0] cur_start;
	logic [31:0] cur_len;

	// Walk state
	logic [31:0] walk_addr;
	logic [30:0] seq_state;
	logic [31:0] bytes_remaining;
	logic [31:0] first_bad;
	logic        pass_over;

	result_t     results_due[$];
	result_t     oldest_due;
	int unsigned sent_total = 0;
	int unsigned errors = 0;
	bit          quiet_phase = 1'b0;

	memory_test_pattern_checker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, none in a quiet phase
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Pattern the next word of the walk would get
	function automatic logic [31:0] upcoming_pattern();
		logic [30:0] nxt;
		nxt = seq_state * SEQ_STEP_MUL + SEQ_STEP_INC;
		case (cur_mode)
			MODE_ADDR: return walk_addr;
			MODE_LCG:  return {1'b0, nxt};
			default:   return cur_fill;
		endcase
	endfunction

	// Advance the walk by one command and return the result it gives
	function automatic result_t advance_walk(logic [1:0] cmd, logic [31:0] rd);
		result_t     r;
		logic [31:0] pat;
		r = '0;
		r.word_address = walk_addr;
		if (cmd == CMD_RESTART) begin
			walk_addr       = cur_start;
			bytes_remaining = cur_len;
			seq_state       = '0;
			first_bad       = ALL_ONES;
			pass_over       = (cur_len == 0);
			r.word_address  = cur_start;
		end else if (cmd != CMD_UNUSED && !pass_over) begin
			pat = upcoming_pattern();
			if (cur_mode == MODE_LCG)
				seq_state = pat[30:0];
			r.pattern = pat;
			walk_addr = walk_addr + 32'd4;
			bytes_remaining = (bytes_remaining <= 32'd4) ? '0 : bytes_remaining - 32'd4;
			if (bytes_remaining == 0)
				pass_over = 1'b1;
			if (cmd == CMD_CHECK && rd != pat) begin
				r.mismatch = 1'b1;
				first_bad  = r.word_address;
				pass_over  = 1'b1;
			end
		end
		r.pass_done    = pass_over;
		r.fail_address = first_bad;
		return r;
	endfunction

	// Write one register while the block is idle
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEST_MODE:     cur_mode  = value[1:0];
			REG_FILL_VALUE:    cur_fill  = value;
			REG_START_ADDRESS: cur_start = value;
			REG_LENGTH_BYTES:  cur_len   = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Send one command word and predict its result on acceptance
	task automatic send_word(logic [1:0] cmd, logic [31:0] rd);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= rd;
		do @(posedge clk); while (!s_tready);
		results_due.push_back(advance_walk(cmd, rd));
		sent_total++;
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
	endtask

	task automatic test_after_reset();
		send_word(CMD_WRITE, 32'h0000_0000);
		send_word(CMD_CHECK, ALL_ONES);
		send_word(CMD_UNUSED, 32'h5a5a_5a5a);
		send_word(CMD_RESTART, 32'h0000_0000);
		send_word(CMD_WRITE, ALL_ONES);
	endtask

	// Constant fill, walk wraps past the top of the address space, partial last word
	task automatic test_constant_wrap();
		drain_results();
		write_reg(REG_TEST_MODE, 32'(MODE_CONST));
		write_reg(REG_FILL_VALUE, ALL_ONES);
		write_reg(REG_START_ADDRESS, 32'hffff_fff8);
		write_reg(REG_LENGTH_BYTES, 32'd9);
		send_word(CMD_RESTART, 32'h0);
		send_word(CMD_WRITE, 32'h0);
		send_word(CMD_CHECK, ALL_ONES);
		send_word(CMD_CHECK, 32'h0);
		send_word(CMD_WRITE, 32'h0);
		send_word(CMD_CHECK, ALL_ONES);
		send_word(CMD_UNUSED, 32'h0);
	endtask

	// Address pattern from an unaligned start
	task automatic test_address_unaligned();
		drain_results();
		write_reg(REG_TEST_MODE, 32'(MODE_ADDR));
		write_reg(REG_START_ADDRESS, 32'h0000_0103);
		write_reg(REG_LENGTH_BYTES, 32'd7);
		send_word(CMD_RESTART, 32'h0);
		send_word(CMD_CHECK, 32'h0000_0103);
		send_word(CMD_UNUSED, ALL_ONES);
		send_word(CMD_CHECK, upcoming_pattern());
		send_word(CMD_WRITE, 32'h0);
	endtask

	// Sequence mode, mixed writes and checks, restart reseeds
	task automatic test_sequence_mode();
		drain_results();
		write_reg(REG_TEST_MODE, 32'(MODE_LCG));
		write_reg(REG_START_ADDRESS, 32'h0000_0000);
		write_reg(REG_LENGTH_BYTES, 32'd12);
		send_word(CMD_RESTART, 32'h0);
		send_word(CMD_WRITE, 32'h0);
		send_word(CMD_CHECK, upcoming_pattern());
		send_word(CMD_CHECK, upcoming_pattern());
		send_word(CMD_RESTART, 32'h0);
		send_word(CMD_WRITE, 32'h0);
	endtask

	// Unused mode code falls back to the fill value
	task automatic test_unused_mode();
		drain_results();
		write_reg(REG_TEST_MODE, 32'(MODE_UNUSED));
		write_reg(REG_FILL_VALUE, 32'h0000_0000);
		write_reg(REG_LENGTH_BYTES, ALL_ONES);
		send_word(CMD_RESTART, 32'h0);
		send_word(CMD_WRITE, 32'h0);
		send_word(CMD_CHECK, ALL_ONES);
	endtask

	// Random passes: new settings per phase, mostly correct read-back
	task automatic test_random_passes(int unsigned target);
		int unsigned phase;
		int          n;
		int          r;
		logic [1:0]  cmd;
		logic [31:0] rd;
		phase = 0;
		while (sent_total < target) begin
			drain_results();
			quiet_phase = (phase % 5 == 4);
			if (phase == 0 || $urandom_range(0, 1)) begin
				r = $urandom_range(0, 9);
				write_reg(REG_TEST_MODE, 32'((r < 3) ? MODE_CONST : (r < 6) ? MODE_ADDR :
					(r < 9) ? MODE_LCG : MODE_UNUSED));
			end
			if (phase == 0 || $urandom_range(0, 1)) begin
				r = $urandom_range(0, 5);
				write_reg(REG_FILL_VALUE, (r == 0) ? 32'h0 : (r == 1) ? ALL_ONES : $urandom);
			end
			if (phase == 0 || $urandom_range(0, 1)) begin
				r = $urandom_range(0, 7);
				write_reg(REG_START_ADDRESS, (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_fff0 :
					(r == 2) ? $urandom : ($urandom & ~32'h3));
			end
			if (phase == 0 || $urandom_range(0, 1)) begin
				r = $urandom_range(0, 19);
				write_reg(REG_LENGTH_BYTES, (r == 0) ? 32'h0 : (r == 1) ? ALL_ONES :
					(r == 2) ? $urandom : (r == 3) ? $urandom_range(1, 3) :
					$urandom_range(4, 96));
			end
			// Now and then keep the live pass going under the new settings
			if ($urandom_range(0, 9) != 0)
				send_word(CMD_RESTART, $urandom);
			n = $urandom_range(1, 30);
			for (int i = 0; i < n; i++) begin
				if (phase % 7 == 3 && i == n / 2)
					drain_results();
				r = $urandom_range(0, 99);
				cmd = (r < 3) ? CMD_RESTART : (r < 6) ? CMD_UNUSED :
					(r < 50) ? CMD_WRITE : CMD_CHECK;
				rd = $urandom;
				if (cmd == CMD_CHECK) begin
					r = $urandom_range(0, 99);
					if (r < 88)
						rd = upcoming_pattern();
					else if (r < 94)
						rd = upcoming_pattern() ^ (32'h1 << $urandom_range(0, 31));
				end
				send_word(cmd, rd);
			end
			phase++;
		end
		quiet_phase = 1'b0;
	endtask

	// Receiver stalls
	initial begin : sink_stall
		int gap;
		int run;
		m_tready = 1'b0;
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result word with none expected, got %h %b %b", $time,
					m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				oldest_due = results_due.pop_front();
				check_field("word_address", oldest_due.word_address, m_tdata[31:0]);
				check_field("pattern", oldest_due.pattern, m_tdata[63:32]);
				check_field("fail_address", oldest_due.fail_address, m_tdata[95:64]);
				check_field("mismatch", 32'(oldest_due.mismatch), 32'(m_tuser));
				check_field("pass_done", 32'(oldest_due.pass_done), 32'(m_tlast));
			end
		end
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_TEST_MODE;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_RESTART;
		cur_mode  = MODE_CONST;
		cur_fill  = '0;
		cur_start = '0;
		cur_len   = '0;
		walk_addr = '0;
		seq_state = '0;
		bytes_remaining = '0;
		first_bad = ALL_ONES;
		pass_over = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_constant_wrap();
		test_address_unaligned();
		test_sequence_mode();
		test_unused_mode();
		test_random_passes(sent_total + RANDOM_ITEMS);

		drain_results();
		// Catch any stray result words
		repeat (20) @(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
